// ===== hw/rtl/mteo_pkg.sv =====
// package: constants, op codes and saturating multiply for the elimination order block
`timescale 1ns / 1ps
`default_nettype none
package mteo_pkg;

    localparam int unsigned MAX_NODES = 64;
    localparam int unsigned NODE_W    = $clog2(MAX_NODES);
    localparam int unsigned MAX_EDGES = 256;
    localparam int unsigned EDGE_W    = $clog2(MAX_EDGES);
    localparam int unsigned ETOT_W    = EDGE_W + 1;
    localparam int unsigned NCNT_W    = 7;
    localparam int unsigned VAL_W     = 8;
    localparam int unsigned SIZE_W    = 63;
    localparam int unsigned DCNT_W    = $clog2(SIZE_W);

    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

    typedef logic [1:0] t_op;
    localparam t_op OP_SET_COUNT = 2'd0;
    localparam t_op OP_ADD_EDGE  = 2'd1;
    localparam t_op OP_RUN       = 2'd2;

    // size times count, saturating at the all-ones size
    function automatic logic [SIZE_W-1:0] sat_mul(input logic [SIZE_W-1:0] a,
                                                  input logic [VAL_W-1:0] v);
        logic [SIZE_W+VAL_W-1:0] prod;
        prod = {{VAL_W{1'b0}}, a} * {{SIZE_W{1'b0}}, v};
        if (a == SIZE_SAT || prod[SIZE_W+VAL_W-1:SIZE_W] != '0) begin
            return SIZE_SAT;
        end
        return prod[SIZE_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/min_table_elimination_order.sv =====
// top level: greedy minimum table size elimination ordering over stored graph
// load requests (set count, add edge) give no result
// throughput: one load request per cycle while idle; a run request holds the input through
//   setup (table sizes from node values, then a multiply pass over the stored edges), then
//   per ordered node a search, an emit step (longer while a result waits) and a pass over
//   the stored edges through the bit-serial divider; then a closing step
// reset: control, edge count, overflow flag and eliminated marks clear; memories keep contents
`timescale 1ns / 1ps
`default_nettype none
module min_table_elimination_order (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [1:0]                      i_operation,
    input  wire logic [mteo_pkg::NODE_W-1:0]     i_node_index,
    input  wire logic [mteo_pkg::VAL_W-1:0]      i_domain_size,
    input  wire logic [mteo_pkg::NODE_W-1:0]     i_edge_from,
    input  wire logic [mteo_pkg::NODE_W-1:0]     i_edge_to,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [mteo_pkg::NODE_W-1:0]          o_node_id,
    output logic [mteo_pkg::NODE_W-1:0]          o_position,
    output logic                                 o_is_last,
    output logic                                 o_edge_overflow,
    // configuration
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mteo_pkg::NCNT_W-1:0]     i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_INIT_RD, S_INIT_WR,
        S_MUL_EDGE, S_MUL_NV, S_MUL_A, S_MUL_RB, S_MUL_B,
        S_SRCH_START, S_SRCH, S_EMIT,
        S_DIV_EDGE, S_DIV_CHK, S_DIV_LD, S_DIV_RUN, S_DIV_WR, S_DONE
    } t_state;

    localparam int unsigned NW = mteo_pkg::NODE_W;
    localparam int unsigned SW = mteo_pkg::SIZE_W;
    localparam int unsigned VW = mteo_pkg::VAL_W;

    t_state                          r_state;
    logic [mteo_pkg::NCNT_W-1:0]     r_node_count;
    logic [mteo_pkg::NCNT_W-1:0]     r_n;
    logic [mteo_pkg::NCNT_W-1:0]     r_i;
    logic [mteo_pkg::NCNT_W-1:0]     r_step;
    logic [mteo_pkg::ETOT_W-1:0]     r_edge_total;
    logic [mteo_pkg::ETOT_W-1:0]     r_e;
    logic                            r_ovf;
    logic [mteo_pkg::MAX_NODES-1:0]  r_elim;
    logic                            r_pend;
    logic                            r_clive;
    logic [NW-1:0]                   r_cidx;
    logic                            r_found;
    logic [NW-1:0]                   r_best;
    logic [SW-1:0]                   r_best_val;
    logic [NW-1:0]                   r_other;
    logic [SW-1:0]                   r_quot;
    logic [VW-1:0]                   r_rem;
    logic [mteo_pkg::DCNT_W-1:0]     r_dcnt;
    logic                            r_ov;
    logic [NW-1:0]                   r_o_node;
    logic [NW-1:0]                   r_o_pos;
    logic                            r_o_last;
    logic                            r_o_ovf;

    // memories and their registered read data
    logic [VW-1:0]   r_nv_mem [mteo_pkg::MAX_NODES];
    logic [11:0]     r_edge_mem [mteo_pkg::MAX_EDGES];
    logic [SW-1:0]   r_ts_mem [mteo_pkg::MAX_NODES];
    logic [VW-1:0]   r_nva_q;
    logic [VW-1:0]   r_nvb_q;
    logic [11:0]     r_edge_q;
    logic [SW-1:0]   r_ts_q;

    logic            in_acc;
    logic            out_free;
    logic [NW-1:0]   ea;
    logic [NW-1:0]   eb;
    logic            e_in_range;
    logic [NW-1:0]   n_pos;
    logic [VW:0]     n_shift;
    logic            n_qbit;
    logic [VW:0]     n_sub;

    logic            nva_re, nvb_re, edge_re, ts_re, ts_we;
    logic [NW-1:0]   nva_addr, nvb_addr, ts_raddr, ts_waddr;
    logic [SW-1:0]   ts_wdata;

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign in_acc          = i_in_valid && !o_in_stall;
    assign out_free        = !r_ov || !i_out_stall;
    assign o_out_valid     = r_ov;
    assign o_node_id       = r_o_node;
    assign o_position      = r_o_pos;
    assign o_is_last       = r_o_last;
    assign o_edge_overflow = r_o_ovf;

    // edge endpoints and range check
    assign ea         = r_edge_q[NW-1:0];
    assign eb         = r_edge_q[2*NW-1:NW];
    assign e_in_range = ({1'b0, ea} < r_n) && ({1'b0, eb} < r_n);
    assign n_pos      = NW'(r_n - 7'd1 - r_step);

    // one restoring division step
    assign n_shift = {r_rem, r_quot[SW-1]};
    assign n_qbit  = (n_shift >= {1'b0, r_nva_q});
    assign n_sub   = n_shift - {1'b0, r_nva_q};

    // memory port control
    always_comb begin
        nva_re   = 1'b0;
        nva_addr = r_i[NW-1:0];
        nvb_re   = 1'b0;
        nvb_addr = eb;
        edge_re  = 1'b0;
        ts_re    = 1'b0;
        ts_raddr = ea;
        ts_we    = 1'b0;
        ts_waddr = ea;
        ts_wdata = r_quot;
        case (r_state)
            S_INIT_RD: begin
                nva_re = (r_i != r_n);
            end
            S_INIT_WR: begin
                ts_we    = 1'b1;
                ts_waddr = r_i[NW-1:0];
                ts_wdata = {{(SW-VW){1'b0}}, r_nva_q};
            end
            S_MUL_EDGE, S_DIV_EDGE: begin
                edge_re = (r_e != r_edge_total);
            end
            S_MUL_NV: begin
                nva_re   = e_in_range;
                nva_addr = ea;
                nvb_re   = e_in_range;
                ts_re    = e_in_range;
            end
            S_MUL_A: begin
                ts_we    = 1'b1;
                ts_wdata = mteo_pkg::sat_mul(r_ts_q, r_nvb_q);
            end
            S_MUL_RB: begin
                ts_re    = 1'b1;
                ts_raddr = eb;
            end
            S_MUL_B: begin
                ts_we    = 1'b1;
                ts_waddr = eb;
                ts_wdata = mteo_pkg::sat_mul(r_ts_q, r_nva_q);
            end
            S_SRCH: begin
                ts_re    = (r_i != r_n);
                ts_raddr = r_i[NW-1:0];
            end
            S_EMIT: begin
                nva_re   = 1'b1;
                nva_addr = r_best;
            end
            S_DIV_CHK: begin
                ts_re    = 1'b1;
                ts_raddr = (ea == r_best) ? eb : ea;
            end
            S_DIV_WR: begin
                ts_we    = 1'b1;
                ts_waddr = r_other;
            end
            default: begin
            end
        endcase
    end

    // node value memory, two read ports
    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == mteo_pkg::OP_SET_COUNT) begin
            r_nv_mem[i_node_index] <= i_domain_size;
        end
        if (nva_re) begin
            r_nva_q <= r_nv_mem[nva_addr];
        end
        if (nvb_re) begin
            r_nvb_q <= r_nv_mem[nvb_addr];
        end
    end

    // edge list memory
    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == mteo_pkg::OP_ADD_EDGE
            && r_edge_total != mteo_pkg::ETOT_W'(mteo_pkg::MAX_EDGES)) begin
            r_edge_mem[r_edge_total[mteo_pkg::EDGE_W-1:0]] <= {i_edge_to, i_edge_from};
        end
        if (edge_re) begin
            r_edge_q <= r_edge_mem[r_e[mteo_pkg::EDGE_W-1:0]];
        end
    end

    // table size memory
    always_ff @(posedge i_clk) begin
        if (ts_we) begin
            r_ts_mem[ts_waddr] <= ts_wdata;
        end
        if (ts_re) begin
            r_ts_q <= r_ts_mem[ts_raddr];
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= mteo_pkg::NCNT_W'(1);
            r_edge_total <= '0;
            r_ovf        <= 1'b0;
            r_elim       <= '0;
            r_ov         <= 1'b0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_n          <= '0;
            r_i          <= '0;
            r_e          <= '0;
            r_step       <= '0;
            r_dcnt       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            // taken result clears unless a new one is loaded in the same cycle
            if (r_ov && !i_out_stall && !(r_state == S_EMIT && out_free)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_operation)
                            mteo_pkg::OP_ADD_EDGE: begin
                                if (r_edge_total
                                    != mteo_pkg::ETOT_W'(mteo_pkg::MAX_EDGES)) begin
                                    r_edge_total <= r_edge_total + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            mteo_pkg::OP_RUN: begin
                                r_n <= (r_node_count > mteo_pkg::NCNT_W'(mteo_pkg::MAX_NODES))
                                     ? mteo_pkg::NCNT_W'(mteo_pkg::MAX_NODES) : r_node_count;
                                r_elim  <= '0;
                                r_i     <= '0;
                                r_state <= S_INIT_RD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_INIT_RD: begin
                    if (r_i == r_n) begin
                        r_e     <= '0;
                        r_state <= S_MUL_EDGE;
                    end else begin
                        r_state <= S_INIT_WR;
                    end
                end
                S_INIT_WR: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= S_INIT_RD;
                end
                S_MUL_EDGE: begin
                    if (r_e == r_edge_total) begin
                        r_step  <= '0;
                        r_state <= S_SRCH_START;
                    end else begin
                        r_state <= S_MUL_NV;
                    end
                end
                S_MUL_NV: begin
                    if (e_in_range) begin
                        r_state <= S_MUL_A;
                    end else begin
                        r_e     <= r_e + 1'b1;
                        r_state <= S_MUL_EDGE;
                    end
                end
                S_MUL_A: begin
                    r_state <= S_MUL_RB;
                end
                S_MUL_RB: begin
                    r_state <= S_MUL_B;
                end
                S_MUL_B: begin
                    r_e     <= r_e + 1'b1;
                    r_state <= S_MUL_EDGE;
                end
                S_SRCH_START: begin
                    r_i     <= '0;
                    r_pend  <= 1'b0;
                    r_found <= 1'b0;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    // compare the size read last cycle
                    if (r_pend && r_clive && (!r_found || r_ts_q < r_best_val)) begin
                        r_found    <= 1'b1;
                        r_best     <= r_cidx;
                        r_best_val <= r_ts_q;
                    end
                    if (r_i != r_n) begin
                        r_pend  <= 1'b1;
                        r_cidx  <= r_i[NW-1:0];
                        r_clive <= !r_elim[r_i[NW-1:0]];
                        r_i     <= r_i + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= r_found ? S_EMIT : S_DONE;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov         <= 1'b1;
                        r_o_node     <= r_best;
                        r_o_pos      <= n_pos;
                        r_o_last     <= (n_pos == '0);
                        r_o_ovf      <= r_ovf;
                        r_elim[r_best] <= 1'b1;
                        r_e          <= '0;
                        r_state      <= S_DIV_EDGE;
                    end
                end
                S_DIV_EDGE: begin
                    if (r_e == r_edge_total) begin
                        r_step  <= r_step + 1'b1;
                        r_state <= (r_step + 1'b1 == r_n) ? S_DONE : S_SRCH_START;
                    end else begin
                        r_state <= S_DIV_CHK;
                    end
                end
                S_DIV_CHK: begin
                    // divide only a live neighbour of the chosen node
                    if (e_in_range && ea == r_best && !r_elim[eb]) begin
                        r_other <= eb;
                        r_state <= S_DIV_LD;
                    end else if (e_in_range && eb == r_best && ea != r_best
                                 && !r_elim[ea]) begin
                        r_other <= ea;
                        r_state <= S_DIV_LD;
                    end else begin
                        r_e     <= r_e + 1'b1;
                        r_state <= S_DIV_EDGE;
                    end
                end
                S_DIV_LD: begin
                    if (r_ts_q == mteo_pkg::SIZE_SAT || r_nva_q == '0) begin
                        r_e     <= r_e + 1'b1;
                        r_state <= S_DIV_EDGE;
                    end else begin
                        r_quot  <= r_ts_q;
                        r_rem   <= '0;
                        r_dcnt  <= mteo_pkg::DCNT_W'(SW - 1);
                        r_state <= S_DIV_RUN;
                    end
                end
                S_DIV_RUN: begin
                    r_quot <= {r_quot[SW-2:0], n_qbit};
                    r_rem  <= n_qbit ? n_sub[VW-1:0] : n_shift[VW-1:0];
                    if (r_dcnt == '0) begin
                        r_state <= S_DIV_WR;
                    end else begin
                        r_dcnt <= r_dcnt - 1'b1;
                    end
                end
                S_DIV_WR: begin
                    r_e     <= r_e + 1'b1;
                    r_state <= S_DIV_EDGE;
                end
                S_DONE: begin
                    r_edge_total <= '0;
                    r_ovf        <= 1'b0;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // edge count never passes capacity
    a_edge_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_total <= mteo_pkg::ETOT_W'(mteo_pkg::MAX_EDGES))
        else $error("edge count beyond capacity");

    // a chosen node is still live when emitted
    a_best_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !r_elim[r_best])
        else $error("eliminated node chosen");

    // searching only while steps remain, or once through an empty run
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_n == '0 || r_step < r_n))
        else $error("search past last position");

    // a new result only replaces a taken one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |=> (r_ov && $stable(r_o_node)))
        else $error("pending result overwritten");

endmodule
`default_nettype wire
